// ===== rtl/assert_macros.svh =====
// Assertion macros shared by the inverse kinematics RTL.
// No dependencies; simulation builds get the checks, synthesis gets nothing.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ASSERT_CLK(label, clk, rst, prop) \
   label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error("%m failed");
`define ASSERT_RST(label, clk, prop) \
   label: assert property (@(posedge clk) (prop)) else $error("%m failed");
`else
`define ASSERT_CLK(label, clk, rst, prop)
`define ASSERT_RST(label, clk, prop)
`endif
`endif

// ===== rtl/aik_pkg.sv =====
// Package for the inverse kinematics block: register indexes and the CORDIC table.
// No dependencies.
package aik_pkg;
   localparam int CORDIC_STEPS = 30;
   localparam logic [1:0] REG_BASE_HEIGHT = 2'd0;
   localparam logic [1:0] REG_UPPER_ARM   = 2'd1;
   localparam logic [1:0] REG_FOREARM     = 2'd2;
   localparam logic [1:0] REG_WRIST_OFS   = 2'd3;

   function automatic logic [31:0] atan_turn(input int i);
      logic [31:0] t;
      case (i)
         0: t = 32'h20000000;  1: t = 32'h12E4051D;  2: t = 32'h09FB385B;
         3: t = 32'h051111D4;  4: t = 32'h028B0D43;  5: t = 32'h0145D7E1;
         6: t = 32'h00A2F61E;  7: t = 32'h00517C55;  8: t = 32'h0028BE53;
         9: t = 32'h00145F2F; 10: t = 32'h000A2F98; 11: t = 32'h000517CC;
         12: t = 32'h00028BE6; 13: t = 32'h000145F3; 14: t = 32'h0000A2FA;
         15: t = 32'h0000517D; 16: t = 32'h000028BE; 17: t = 32'h0000145F;
         18: t = 32'h00000A30; 19: t = 32'h00000518; 20: t = 32'h0000028C;
         21: t = 32'h00000146; 22: t = 32'h000000A3; 23: t = 32'h00000051;
         24: t = 32'h00000029; 25: t = 32'h00000014; 26: t = 32'h0000000A;
         27: t = 32'h00000005; 28: t = 32'h00000003; default: t = 32'h00000001;
      endcase
      return t;
   endfunction
endpackage

// ===== rtl/aik_stream_if.sv =====
// Valid/ready channel interface carrying a payload of parameterised type.
// Depends on nothing.
interface aik_stream_if #(parameter type PAYLOAD_type = logic);
   logic        valid;
   logic        ready;
   PAYLOAD_type data;
   modport source (output valid, output data, input ready);
   modport sink (input valid, input data, output ready);
endinterface

// ===== rtl/aik_isqrt.sv =====
// Pipelined floor square root, one result bit per stage, with a side payload.
// Depends on assert_macros.svh.
`include "assert_macros.svh"
module aik_isqrt #(
   parameter int IN_BITS = 100,
   parameter int SIDE_BITS = 8
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          advance,
   input  logic                          in_valid,
   input  logic [IN_BITS-1:0]            in_value,
   input  logic [SIDE_BITS-1:0]          in_side,
   output logic                          out_valid,
   output logic [(IN_BITS+1)/2-1:0]      out_root,
   output logic [SIDE_BITS-1:0]          out_side
);
   localparam int RB = (IN_BITS + 1) / 2;
   localparam int WB = 2 * RB;
   logic [WB-1:0]        rem_ff  [1:RB];
   logic [RB-1:0]        root_ff [1:RB];
   logic [SIDE_BITS-1:0] side_ff [1:RB];
   logic                 vld_ff  [1:RB];

   // Each stage keeps the remainder v - root^2 and tries the next root bit
   // with a compare and subtract: (root + 2^B)^2 - root^2 = root * 2^(B+1) + 2^(2B).
   for (genvar k = 0; k < RB; k++) begin : g_stage
      localparam int B = RB - 1 - k;
      logic [WB-1:0]        rem_w;
      logic [RB-1:0]        root_w;
      logic [SIDE_BITS-1:0] side_w;
      logic                 vld_w;
      logic [WB-1:0]        trial_w;
      if (k == 0) begin : g_first
         assign rem_w  = WB'(in_value);
         assign root_w = '0;
         assign side_w = in_side;
         assign vld_w  = in_valid;
      end else begin : g_next
         assign rem_w  = rem_ff[k];
         assign root_w = root_ff[k];
         assign side_w = side_ff[k];
         assign vld_w  = vld_ff[k];
      end
      assign trial_w = (WB'(root_w) << (B + 1)) | (WB'(1) << (2 * B));
      always_ff @(posedge clock) begin
         if (reset) begin
            vld_ff[k+1] <= 1'b0;
         end else if (advance) begin
            vld_ff[k+1] <= vld_w;
         end
         if (advance) begin
            side_ff[k+1] <= side_w;
            if (rem_w >= trial_w) begin
               rem_ff[k+1]  <= rem_w - trial_w;
               root_ff[k+1] <= root_w | (RB'(1) << B);
            end else begin
               rem_ff[k+1]  <= rem_w;
               root_ff[k+1] <= root_w;
            end
         end
      end
   end

   assign out_valid = vld_ff[RB];
   assign out_root  = root_ff[RB];
   assign out_side  = side_ff[RB];
endmodule

// ===== rtl/aik_cordic.sv =====
// Pipelined vectoring CORDIC: atan2 in 2^-32 turn (doubled when DOUBLE is set), rounded to a binary angle.
// Depends on aik_pkg.
module aik_cordic #(
   parameter int IN_BITS = 52,
   parameter int ANGLE_BITS = 16,
   parameter int SIDE_BITS = 8,
   parameter bit DOUBLE = 1'b0
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         advance,
   input  logic                         in_valid,
   input  logic signed [IN_BITS-1:0]    in_y,
   input  logic signed [IN_BITS-1:0]    in_x,
   input  logic [SIDE_BITS-1:0]         in_side,
   output logic                         out_valid,
   output logic [ANGLE_BITS-1:0]        out_angle,
   output logic [SIDE_BITS-1:0]         out_side
);
   localparam int N = aik_pkg::CORDIC_STEPS;
   localparam int W = 56;
   localparam logic signed [W-1:0] LIM = W'(64'sd1 << 50);
   logic signed [W-1:0]  x_ff [1:N];
   logic signed [W-1:0]  y_ff [1:N];
   logic [31:0]          z_ff [1:N];
   logic                 zr_ff [1:N];
   logic                 v_ff [1:N];
   logic [SIDE_BITS-1:0] s_ff [1:N];

   logic signed [W-1:0] xa, ya, xn, yn;
   logic [31:0]         z0;
   logic                zero;
   logic [5:0]          sh;
   always_comb begin
      xa = W'(in_x);
      ya = W'(in_y);
      zero = (xa == 0) && (ya == 0);
      z0 = 32'h0;
      if (xa < 0) begin
         xa = -xa;
         ya = -ya;
         z0 = 32'h80000000;
      end
      // Doubling until one magnitude reaches the limit: find the shift directly.
      sh = 6'd0;
      for (int k = 1; k <= 52; k++) begin
         if (((xa <<< (k - 1)) < LIM) && ((ya <<< (k - 1)) < LIM)
             && ((ya <<< (k - 1)) > -LIM) && (sh == 6'(k - 1)) && !zero)
            sh = 6'(k);
      end
      xn = xa <<< sh;
      yn = ya <<< sh;
   end

   for (genvar i = 0; i < N; i++) begin : g_step
      logic signed [W-1:0]  x_w, y_w;
      logic [31:0]          z_w;
      logic                 zr_w, v_w;
      logic [SIDE_BITS-1:0] s_w;
      if (i == 0) begin : g_head
         assign x_w  = xn;
         assign y_w  = yn;
         assign z_w  = z0;
         assign zr_w = zero;
         assign v_w  = in_valid;
         assign s_w  = in_side;
      end else begin : g_body
         assign x_w  = x_ff[i];
         assign y_w  = y_ff[i];
         assign z_w  = z_ff[i];
         assign zr_w = zr_ff[i];
         assign v_w  = v_ff[i];
         assign s_w  = s_ff[i];
      end
      always_ff @(posedge clock) begin
         if (reset) begin
            v_ff[i+1] <= 1'b0;
         end else if (advance) begin
            v_ff[i+1] <= v_w;
         end
         if (advance) begin
            s_ff[i+1]  <= s_w;
            zr_ff[i+1] <= zr_w;
            if (y_w >= 0) begin
               x_ff[i+1] <= x_w + (y_w >>> i);
               y_ff[i+1] <= y_w - (x_w >>> i);
               z_ff[i+1] <= z_w + aik_pkg::atan_turn(i);
            end else begin
               x_ff[i+1] <= x_w - (y_w >>> i);
               y_ff[i+1] <= y_w + (x_w >>> i);
               z_ff[i+1] <= z_w - aik_pkg::atan_turn(i);
            end
         end
      end
   end

   logic [31:0] zf;
   always_comb begin
      zf = zr_ff[N] ? 32'h0 : z_ff[N];
      if (DOUBLE) zf = {zf[30:0], 1'b0};
      zf = zf + (32'h1 << (31 - ANGLE_BITS));
   end
   assign out_angle = zf[31 -: ANGLE_BITS];
   assign out_valid = v_ff[N];
   assign out_side  = s_ff[N];
endmodule

// ===== rtl/arm_inverse_kinematics_5dof.sv =====
// Five-joint arm inverse kinematics, fully pipelined.
// Throughput: one transaction per cycle while the output is not stalled. The stages run:
// squares, radius root, planar terms and split product, planar roots, CORDIC, output.
// The depth is set by the bit-per-stage roots and the 30 CORDIC stages.
// A stalled output freezes the whole pipe.
// Reset: synchronous, active high; clears all valid bits and restores register defaults.
`include "assert_macros.svh"
module arm_inverse_kinematics_5dof #(
   parameter int POS_BITS = 24,
   parameter int ANGLE_BITS = 16
) (
   input  logic          clock,
   input  logic          reset,
   input  logic          csr_write,
   input  logic [1:0]    csr_index,
   input  logic [POS_BITS-1:0] csr_data,
   aik_stream_if.sink    req,
   aik_stream_if.source  rsp
);
   localparam int WS = (POS_BITS > 24) ? POS_BITS - 24 : 0;
   localparam int SQ_IN = 2 * POS_BITS + 2;
   localparam int PW = 2 * POS_BITS + 4;
   localparam int CW = 52;
   localparam int AB = ANGLE_BITS;

   // Configuration registers.
   logic signed [POS_BITS-1:0] base_height_ff, wrist_offset_ff;
   logic [POS_BITS-2:0]        upper_arm_ff, forearm_ff;
   always_ff @(posedge clock) begin
      if (reset) begin
         base_height_ff <= '0;
         upper_arm_ff   <= (POS_BITS-1)'(25600);
         forearm_ff     <= (POS_BITS-1)'(25600);
         wrist_offset_ff <= '0;
      end else if (csr_write) begin
         case (csr_index)
            aik_pkg::REG_BASE_HEIGHT: base_height_ff <= csr_data;
            aik_pkg::REG_UPPER_ARM:   upper_arm_ff <= csr_data[POS_BITS-2:0];
            aik_pkg::REG_FOREARM:     forearm_ff <= csr_data[POS_BITS-2:0];
            aik_pkg::REG_WRIST_OFS:   wrist_offset_ff <= csr_data;
            default: ;
         endcase
      end
   end

   // The whole pipe moves when the output stage is free or empty.
   logic advance, out_vld_ff;
   assign advance   = !out_vld_ff || rsp.ready;
   assign req.ready = advance;

   // Stage A: squares of x and y.
   typedef struct packed {
      logic signed [POS_BITS-1:0] x, y, z;
      logic [AB-1:0] pitch, roll;
   } pose_type;
   pose_type pose_in;
   assign pose_in = '{x: req.data.target_x, y: req.data.target_y, z: req.data.target_z,
                      pitch: req.data.target_pitch, roll: req.data.target_roll};
   logic a_vld_ff; pose_type a_pose_ff;
   logic [SQ_IN-1:0] a_xx_ff, a_yy_ff;
   always_ff @(posedge clock) begin
      if (reset) a_vld_ff <= 1'b0;
      else if (advance) a_vld_ff <= req.valid;
      if (advance) begin
         a_pose_ff <= pose_in;
         a_xx_ff <= SQ_IN'($signed(pose_in.x) * $signed(pose_in.x));
         a_yy_ff <= SQ_IN'($signed(pose_in.y) * $signed(pose_in.y));
      end
   end
   logic b_vld_ff; pose_type b_pose_ff; logic [SQ_IN-1:0] b_sum_ff;
   always_ff @(posedge clock) begin
      if (reset) b_vld_ff <= 1'b0;
      else if (advance) b_vld_ff <= a_vld_ff;
      if (advance) begin
         b_pose_ff <= a_pose_ff;
         b_sum_ff  <= a_xx_ff + a_yy_ff;
      end
   end

   // Radius root.
   localparam int RB = (SQ_IN + 1) / 2;
   logic c_vld; logic [RB-1:0] c_rad; pose_type c_pose;
   aik_isqrt #(.IN_BITS(SQ_IN), .SIDE_BITS($bits(pose_type))) u_rad (
      .clock, .reset, .advance, .in_valid(b_vld_ff), .in_value(b_sum_ff),
      .in_side(b_pose_ff), .out_valid(c_vld), .out_root(c_rad), .out_side(c_pose));

   // Stage D: r, s, reach checks and squared terms.
   typedef struct packed {
      pose_type pose;
      logic signed [POS_BITS+1:0] r, s;
      logic ok;
      logic [PW-1:0] p, q;
      logic signed [PW+1:0] m;
   } plan_type;
   logic signed [POS_BITS+1:0] r_w, s_w, rw_w, sw_w, ar_w, as_w;
   logic [POS_BITS-1:0] l1_w, l2_w, reach_w, diff_w;
   always_comb begin
      r_w = (POS_BITS+2)'(c_rad) - (POS_BITS+2)'(wrist_offset_ff);
      s_w = (POS_BITS+2)'(c_pose.z) - (POS_BITS+2)'(base_height_ff);
      rw_w = r_w >>> WS;
      sw_w = s_w >>> WS;
      ar_w = rw_w < 0 ? -rw_w : rw_w;
      as_w = sw_w < 0 ? -sw_w : sw_w;
      l1_w = POS_BITS'(upper_arm_ff >> WS);
      l2_w = POS_BITS'(forearm_ff >> WS);
      reach_w = l1_w + l2_w;
      diff_w = l1_w > l2_w ? l1_w - l2_w : l2_w - l1_w;
   end
   logic d_vld_ff, d_ok_ff; pose_type d_pose_ff;
   logic signed [POS_BITS+1:0] d_r_ff, d_s_ff;
   logic [PW-1:0] d_dd_ff, d_rr_ff, d_ff2, d_l1_ff, d_l2_ff;
   always_ff @(posedge clock) begin
      if (reset) d_vld_ff <= 1'b0;
      else if (advance) d_vld_ff <= c_vld;
      if (advance) begin
         d_pose_ff <= c_pose;
         d_r_ff <= r_w; d_s_ff <= s_w;
         d_ok_ff <= (l1_w != 0) && (l2_w != 0) && (ar_w <= $signed({2'b0, reach_w}))
                    && (as_w <= $signed({2'b0, reach_w}));
         d_dd_ff <= PW'(rw_w * rw_w) + PW'(sw_w * sw_w);
         d_rr_ff <= PW'(reach_w) * PW'(reach_w);
         d_ff2   <= PW'(diff_w) * PW'(diff_w);
         d_l1_ff <= PW'(l1_w) * PW'(l1_w);
         d_l2_ff <= PW'(l2_w) * PW'(l2_w);
      end
   end
   plan_type e_plan_in;
   always_comb begin
      e_plan_in.pose = d_pose_ff;
      e_plan_in.r = d_r_ff; e_plan_in.s = d_s_ff;
      e_plan_in.ok = d_ok_ff && (d_dd_ff <= d_rr_ff) && (d_dd_ff >= d_ff2);
      e_plan_in.p = d_rr_ff - d_dd_ff;
      e_plan_in.q = d_dd_ff - d_ff2;
      e_plan_in.m = (PW+2)'(d_dd_ff) + (PW+2)'(d_l1_ff) - (PW+2)'(d_l2_ff);
   end

   // Stage E: the links are below 2^23 after the work shift, so p and q fit in
   // 48 bits whenever the target is reachable. Their product is built from four
   // 24 by 24 partial products here and summed in stage H.
   logic [47:0] p48_w, q48_w;
   logic [23:0] p_lo_w, p_hi_w, q_lo_w, q_hi_w;
   assign p48_w  = 48'(e_plan_in.p);
   assign q48_w  = 48'(e_plan_in.q);
   assign p_lo_w = p48_w[23:0];
   assign p_hi_w = p48_w[47:24];
   assign q_lo_w = q48_w[23:0];
   assign q_hi_w = q48_w[47:24];
   logic e_vld_ff; plan_type e_plan_ff;
   logic [47:0] e_pp_ll_ff, e_pp_lh_ff, e_pp_hl_ff, e_pp_hh_ff;
   always_ff @(posedge clock) begin
      if (reset) e_vld_ff <= 1'b0;
      else if (advance) e_vld_ff <= d_vld_ff;
      if (advance) begin
         e_plan_ff  <= e_plan_in;
         e_pp_ll_ff <= 48'(p_lo_w) * 48'(q_lo_w);
         e_pp_lh_ff <= 48'(p_lo_w) * 48'(q_hi_w);
         e_pp_hl_ff <= 48'(p_hi_w) * 48'(q_lo_w);
         e_pp_hh_ff <= 48'(p_hi_w) * 48'(q_hi_w);
      end
   end

   // Stage H: sum of the partial products.
   logic [95:0] pq_w;
   assign pq_w = {e_pp_hh_ff, 48'd0} + {24'd0, e_pp_lh_ff, 24'd0}
               + {24'd0, e_pp_hl_ff, 24'd0} + {48'd0, e_pp_ll_ff};
   logic h_vld_ff; plan_type h_plan_ff; logic [2*PW-1:0] h_pq_ff;
   always_ff @(posedge clock) begin
      if (reset) h_vld_ff <= 1'b0;
      else if (advance) h_vld_ff <= e_vld_ff;
      if (advance) begin
         h_plan_ff <= e_plan_ff;
         h_pq_ff   <= (2*PW)'(pq_w);
      end
   end

   // Three roots run side by side; the plan rides with the product root.
   logic f_vld, f_vp, f_vq; plan_type f_plan;
   logic [PW-1:0] f_sp, f_sq, f_spq;
   aik_isqrt #(.IN_BITS(2*PW), .SIDE_BITS($bits(plan_type))) u_pq (
      .clock, .reset, .advance, .in_valid(h_vld_ff), .in_value(h_pq_ff),
      .in_side(h_plan_ff), .out_valid(f_vld), .out_root(f_spq), .out_side(f_plan));
   aik_isqrt #(.IN_BITS(2*PW), .SIDE_BITS(1)) u_p (
      .clock, .reset, .advance, .in_valid(h_vld_ff), .in_value((2*PW)'(h_plan_ff.p)),
      .in_side(1'b0), .out_valid(f_vp), .out_root(f_sp), .out_side());
   aik_isqrt #(.IN_BITS(2*PW), .SIDE_BITS(1)) u_q (
      .clock, .reset, .advance, .in_valid(h_vld_ff), .in_value((2*PW)'(h_plan_ff.q)),
      .in_side(1'b0), .out_valid(f_vq), .out_root(f_sq), .out_side());

   // CORDICs.
   typedef struct packed {
      logic ok;
      logic [AB-1:0] pitch, roll;
   } tail_type;
   logic g_vld, g_v1, g_v2, g_v3;
   logic [AB-1:0] g_base, g_elbow, g_alpha, g_beta;
   tail_type g_tail, tail_in;
   assign tail_in = '{ok: f_plan.ok, pitch: f_plan.pose.pitch, roll: f_plan.pose.roll};
   aik_cordic #(.IN_BITS(CW), .ANGLE_BITS(AB), .SIDE_BITS($bits(tail_type))) u_base (
      .clock, .reset, .advance, .in_valid(f_vld), .in_y(CW'(f_plan.pose.y)),
      .in_x(CW'(f_plan.pose.x)), .in_side(tail_in), .out_valid(g_vld),
      .out_angle(g_base), .out_side(g_tail));
   aik_cordic #(.IN_BITS(CW), .ANGLE_BITS(AB), .SIDE_BITS(1), .DOUBLE(1'b1)) u_elb (
      .clock, .reset, .advance, .in_valid(f_vp), .in_y(CW'(f_sp)),
      .in_x(CW'(f_sq)), .in_side(1'b0), .out_valid(g_v1), .out_angle(g_elbow),
      .out_side());
   aik_cordic #(.IN_BITS(CW), .ANGLE_BITS(AB), .SIDE_BITS(1)) u_alpha (
      .clock, .reset, .advance, .in_valid(f_vq), .in_y(CW'(f_plan.s)),
      .in_x(CW'(f_plan.r)), .in_side(1'b0), .out_valid(g_v2), .out_angle(g_alpha),
      .out_side());
   aik_cordic #(.IN_BITS(CW), .ANGLE_BITS(AB), .SIDE_BITS(1)) u_beta (
      .clock, .reset, .advance, .in_valid(f_vld), .in_y(CW'(f_spq)),
      .in_x(CW'(f_plan.m)), .in_side(1'b0), .out_valid(g_v3), .out_angle(g_beta),
      .out_side());

   // Output register.
   logic [AB-1:0] shoulder_w, wrist_w;
   assign shoulder_w = g_alpha - g_beta;
   assign wrist_w = g_tail.pitch - shoulder_w - g_elbow;
   always_ff @(posedge clock) begin
      if (reset) out_vld_ff <= 1'b0;
      else if (advance) out_vld_ff <= g_vld;
      if (advance) begin
         rsp.data.reachable      <= g_tail.ok;
         rsp.data.base_angle     <= g_tail.ok ? g_base : '0;
         rsp.data.shoulder_angle <= g_tail.ok ? shoulder_w : '0;
         rsp.data.elbow_angle    <= g_tail.ok ? g_elbow : '0;
         rsp.data.wrist_angle    <= g_tail.ok ? wrist_w : '0;
         rsp.data.hand_angle     <= g_tail.ok ? g_tail.roll : '0;
      end
   end
   assign rsp.valid = out_vld_ff;

   // The parallel lanes must stay in step.
   `ASSERT_CLK(a_lanes, clock, reset, g_vld == g_v1 && g_vld == g_v3 && g_vld == g_v2)
   `ASSERT_CLK(a_roots, clock, reset, f_vld == f_vp && f_vld == f_vq)
   `ASSERT_CLK(a_hold, clock, reset, (rsp.valid && !rsp.ready) |=> rsp.valid)
endmodule
